// ===== rtl/pts_pkg.sv =====
// Shared types and constants for the pump transfer and stir sequencer.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    // command codes
    localparam logic [2:0] FUNC_UPDATE      = 3'd0;
    localparam logic [2:0] FUNC_XFER_START  = 3'd1;
    localparam logic [2:0] FUNC_XFER_STOP   = 3'd2;
    localparam logic [2:0] FUNC_STIR_START  = 3'd3;
    localparam logic [2:0] FUNC_STIR_STOP   = 3'd4;
    localparam logic [2:0] FUNC_STOP_ALL    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_LITRES = 2'd0;
    localparam logic [1:0] REG_STIR_ON_SEC   = 2'd1;
    localparam logic [1:0] REG_STIR_OFF_SEC  = 2'd2;

    typedef enum logic [1:0] {
        XFER_INACTIVE = 2'd0,
        XFER_RUNNING  = 2'd1,
        XFER_DONE     = 2'd2
    } pts_xfer_t;

    typedef enum logic [1:0] {
        STIR_INACTIVE  = 2'd0,
        STIR_ON        = 2'd1,
        STIR_PAUSE     = 2'd2,
        STIR_SUSPENDED = 2'd3
    } pts_stir_t;

    typedef enum logic [1:0] {
        PUMP_NONE = 2'd0,
        PUMP_OFF  = 2'd1,
        PUMP_ON   = 2'd2
    } pts_pump_t;

    typedef enum logic [1:0] {
        VALVE_NONE     = 2'd0,
        VALVE_STIR     = 2'd1,
        VALVE_TRANSFER = 2'd2
    } pts_valve_t;

    typedef struct packed {
        logic [15:0] target_litres;
        logic [15:0] stir_on_seconds;
        logic [15:0] stir_off_seconds;
    } pts_cfg_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] time_ms;
        logic [31:0] session_volume;
        logic        pump_feedback;
        logic        valve_feedback;
    } pts_item_t;

    typedef struct packed {
        pts_pump_t          pump_drive;
        pts_valve_t         valve_drive;
        pts_xfer_t          transfer_status;
        pts_stir_t          stir_status;
        logic               manual_transfer;
        logic signed [31:0] moved_volume;
        logic [25:0]        stir_remaining_ms;
    } pts_result_t;

endpackage
`default_nettype wire

// ===== rtl/pts_cfg_regs.sv =====
// Configuration register file for the sequencer limits.
`timescale 1ns / 1ps
`default_nettype none
module pts_cfg_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [1:0]        wr_index,
    input  wire logic [15:0]       wr_data,
    output pts_pkg::pts_cfg_t      cfg
);
    import pts_pkg::*;

    pts_cfg_t cfg_reg;
    pts_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_TARGET_LITRES: cfg_next.target_litres    = wr_data;
                REG_STIR_ON_SEC:   cfg_next.stir_on_seconds  = wr_data;
                REG_STIR_OFF_SEC:  cfg_next.stir_off_seconds = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/pts_core.sv =====
// Transfer and stir automata: state registers and one-step next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module pts_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire pts_pkg::pts_item_t item,
    input  wire pts_pkg::pts_cfg_t cfg,
    output pts_pkg::pts_result_t   result
);
    import pts_pkg::*;

    pts_xfer_t   xfer_reg,   xfer_next;
    pts_stir_t   stir_reg,   stir_next;
    logic        manual_reg, manual_next;
    logic [31:0] start_vol_reg, start_vol_next;
    logic [31:0] moved_reg,  moved_next;
    logic [31:0] phase_ms_reg, phase_ms_next;
    logic [15:0] target_reg, target_next;
    logic [25:0] on_ms_reg,  on_ms_next;
    logic [25:0] off_ms_reg, off_ms_next;

    pts_pump_t   pump_cmd;
    pts_valve_t  valve_cmd;
    logic        pump_run;
    logic        valve_xfer;
    logic        moving;
    logic [32:0] diff;
    logic [31:0] elapsed;
    logic [31:0] elapsed_out;
    logic [25:0] phase_len;
    logic [25:0] remaining;

    always_comb begin
        xfer_next      = xfer_reg;
        stir_next      = stir_reg;
        manual_next    = manual_reg;
        start_vol_next = start_vol_reg;
        moved_next     = moved_reg;
        phase_ms_next  = phase_ms_reg;
        target_next    = target_reg;
        on_ms_next     = on_ms_reg;
        off_ms_next    = off_ms_reg;
        pump_cmd       = PUMP_NONE;
        valve_cmd      = VALVE_NONE;
        pump_run       = 1'b0;
        valve_xfer     = 1'b0;
        moving         = 1'b0;
        diff           = '0;
        elapsed        = '0;

        unique case (item.func)
            FUNC_UPDATE: begin
                // done closes here; a suspended stir resumes
                if (xfer_next == XFER_DONE) begin
                    pump_cmd  = PUMP_OFF;
                    valve_cmd = VALVE_STIR;
                    xfer_next = XFER_INACTIVE;
                    if (stir_next == STIR_SUSPENDED) begin
                        stir_next     = STIR_ON;
                        phase_ms_next = item.time_ms;
                        pump_cmd      = PUMP_ON;
                    end
                end
                pump_run   = (pump_cmd == PUMP_NONE) ? item.pump_feedback
                                                     : (pump_cmd == PUMP_ON);
                valve_xfer = (valve_cmd == VALVE_NONE) ? item.valve_feedback
                                                       : (valve_cmd == VALVE_TRANSFER);
                moving     = pump_run && valve_xfer;

                if (moving && (xfer_next == XFER_INACTIVE) && !manual_next) begin
                    manual_next    = 1'b1;
                    start_vol_next = item.session_volume;
                    moved_next     = '0;
                end
                if (manual_next && !moving) begin
                    manual_next = 1'b0;
                end
                if (moving) begin
                    diff = {1'b0, item.session_volume} - {1'b0, start_vol_next};
                    if (diff[32] != diff[31]) begin
                        moved_next = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        moved_next = diff[31:0];
                    end
                end

                if (xfer_next == XFER_RUNNING &&
                    $signed(moved_next) >= $signed({8'd0, target_next, 8'd0})) begin
                    pump_cmd  = PUMP_OFF;
                    valve_cmd = VALVE_STIR;
                    xfer_next = XFER_DONE;
                end

                elapsed = item.time_ms - phase_ms_next;
                if (stir_next == STIR_ON) begin
                    if (elapsed >= {6'd0, on_ms_next}) begin
                        pump_cmd      = PUMP_OFF;
                        stir_next     = STIR_PAUSE;
                        phase_ms_next = item.time_ms;
                    end
                end else if (stir_next == STIR_PAUSE) begin
                    if (elapsed >= {6'd0, off_ms_next}) begin
                        valve_cmd     = VALVE_STIR;
                        pump_cmd      = PUMP_ON;
                        stir_next     = STIR_ON;
                        phase_ms_next = item.time_ms;
                    end
                end
            end
            FUNC_XFER_START: begin
                if (xfer_reg != XFER_RUNNING) begin
                    target_next    = cfg.target_litres;
                    start_vol_next = item.session_volume;
                    xfer_next      = XFER_RUNNING;
                    moved_next     = '0;
                    valve_cmd      = VALVE_TRANSFER;
                    pump_cmd       = PUMP_ON;
                    if (stir_reg == STIR_ON || stir_reg == STIR_PAUSE) begin
                        stir_next = STIR_SUSPENDED;
                    end
                end
            end
            FUNC_XFER_STOP: begin
                if (xfer_reg != XFER_INACTIVE) begin
                    pump_cmd  = PUMP_OFF;
                    valve_cmd = VALVE_STIR;
                    xfer_next = XFER_INACTIVE;
                    if (stir_reg == STIR_SUSPENDED) begin
                        stir_next     = STIR_ON;
                        phase_ms_next = item.time_ms;
                        pump_cmd      = PUMP_ON;
                    end
                end
            end
            FUNC_STIR_START: begin
                if (stir_reg == STIR_INACTIVE) begin
                    on_ms_next    = {10'd0, cfg.stir_on_seconds}  * {16'd0, MS_PER_S};
                    off_ms_next   = {10'd0, cfg.stir_off_seconds} * {16'd0, MS_PER_S};
                    phase_ms_next = item.time_ms;
                    if (xfer_reg == XFER_RUNNING) begin
                        stir_next = STIR_SUSPENDED;
                    end else begin
                        stir_next = STIR_ON;
                        valve_cmd = VALVE_STIR;
                        pump_cmd  = PUMP_ON;
                    end
                end
            end
            FUNC_STIR_STOP: begin
                if (stir_reg != STIR_INACTIVE) begin
                    if (xfer_reg != XFER_RUNNING) begin
                        pump_cmd = PUMP_OFF;
                    end
                    stir_next = STIR_INACTIVE;
                end
            end
            FUNC_STOP_ALL: begin
                if (!(xfer_reg == XFER_INACTIVE && stir_reg == STIR_INACTIVE)) begin
                    if (xfer_reg == XFER_RUNNING) begin
                        pump_cmd  = PUMP_OFF;
                        valve_cmd = VALVE_STIR;
                    end else if (stir_reg == STIR_ON) begin
                        pump_cmd = PUMP_OFF;
                    end
                    xfer_next = XFER_INACTIVE;
                    stir_next = STIR_INACTIVE;
                end
            end
            default: ;
        endcase
    end

    // remaining time of the current stir phase, from the post-step state
    always_comb begin
        elapsed_out = item.time_ms - phase_ms_next;
        phase_len   = (stir_next == STIR_ON) ? on_ms_next : off_ms_next;
        remaining   = '0;
        if (stir_next == STIR_ON || stir_next == STIR_PAUSE) begin
            if (elapsed_out < {6'd0, phase_len}) begin
                remaining = phase_len - elapsed_out[25:0];
            end
        end
    end

    always_comb begin
        result.pump_drive        = pump_cmd;
        result.valve_drive       = valve_cmd;
        result.transfer_status   = xfer_next;
        result.stir_status       = stir_next;
        result.manual_transfer   = manual_next;
        result.moved_volume      = moved_next;
        result.stir_remaining_ms = remaining;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xfer_reg      <= XFER_INACTIVE;
            stir_reg      <= STIR_INACTIVE;
            manual_reg    <= 1'b0;
            start_vol_reg <= '0;
            moved_reg     <= '0;
            phase_ms_reg  <= '0;
            target_reg    <= '0;
            on_ms_reg     <= '0;
            off_ms_reg    <= '0;
        end else if (advance) begin
            xfer_reg      <= xfer_next;
            stir_reg      <= stir_next;
            manual_reg    <= manual_next;
            start_vol_reg <= start_vol_next;
            moved_reg     <= moved_next;
            phase_ms_reg  <= phase_ms_next;
            target_reg    <= target_next;
            on_ms_reg     <= on_ms_next;
            off_ms_reg    <= off_ms_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pump_transfer_and_stir_sequencer.sv =====
// Top level of the pump transfer and stir sequencer: stream ports and beat registers.
// A beat goes from the input register through the step logic to the result register.
// Throughput: one beat per cycle while the output is not stalled; the input register
// feeds the step logic, whose result and next state are registered at the same edge.
// Reset: synchronous, active low; clears both automata, volumes, latched
// limits, the configuration registers and the valid flags of both beat registers.
`timescale 1ns / 1ps
`default_nettype none
module pump_transfer_and_stir_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [71:0] s_tdata,   // time_ms, session_volume, pump_feedback,
                                        // valve_feedback, zero pad
    input  wire logic [2:0]  s_tuser,   // func
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [71:0] m_tdata,   // pump_drive, valve_drive, transfer_status,
                                        // stir_status, manual_transfer, moved_volume,
                                        // stir_remaining_ms, zero pad
    // configuration
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import pts_pkg::*;

    logic        s1_vld_reg;
    pts_item_t   s1_item_reg;
    logic        m_vld_reg;
    pts_result_t m_res_reg;
    logic        s1_move;
    pts_cfg_t    cfg;
    pts_result_t step_res;
    pts_item_t   in_item;

    assign cfg_ready = 1'b1;

    pts_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb begin
        in_item.func           = s_tuser;
        in_item.time_ms        = s_tdata[31:0];
        in_item.session_volume = s_tdata[63:32];
        in_item.pump_feedback  = s_tdata[64];
        in_item.valve_feedback = s_tdata[65];
    end

    assign s1_move  = s1_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_move;

    pts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s1_move),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_vld_reg <= s_tvalid;
            end
            if (s1_move) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_item_reg <= in_item;
        end
        if (s1_move) begin
            m_res_reg <= step_res;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'd0,
                       m_res_reg.stir_remaining_ms,
                       m_res_reg.moved_volume,
                       m_res_reg.manual_transfer,
                       m_res_reg.stir_status,
                       m_res_reg.transfer_status,
                       m_res_reg.valve_drive,
                       m_res_reg.pump_drive};

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_vld_reg || m_tready) |-> s_tready)
        else $error("input stalled while output side free");

    a_step_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move |=> m_vld_reg)
        else $error("step taken without result beat");

    a_remaining_only_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && m_res_reg.stir_remaining_ms != 26'd0) |->
        (m_res_reg.stir_status == STIR_ON || m_res_reg.stir_status == STIR_PAUSE))
        else $error("stir time reported outside on or pause");

    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled with a free slot");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for the pump transfer and stir sequencer: directed and random streams.
`timescale 1ns / 1ps
module tb;
    import pts_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] FUNC_NOP_A = 3'd6;
    localparam logic [2:0] FUNC_NOP_B = 3'd7;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // time_ms, session_volume, pump_feedback, valve_feedback, pad
    logic [2:0]  s_tuser = '0;     // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // pump, valve, xfer, stir, manual, moved, remaining, pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pump_transfer_and_stir_sequencer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // sequencer mirror
    pts_xfer_t          xfer_ph = XFER_INACTIVE;
    pts_stir_t          stir_ph = STIR_INACTIVE;
    logic               manual_seen = 1'b0;
    logic [31:0]        base_vol = '0;
    logic signed [31:0] moved_vol = '0;
    logic [31:0]        phase_t0 = '0;
    logic [15:0]        held_target = '0;
    logic [25:0]        held_on_ms = '0;
    logic [25:0]        held_off_ms = '0;
    logic [15:0]        reg_target = '0;
    logic [15:0]        reg_on_s = '0;
    logic [15:0]        reg_off_s = '0;
    pts_pump_t          pump_cmd = PUMP_NONE;
    pts_valve_t         valve_cmd = VALVE_NONE;

    pts_result_t results_due[$];
    int          fail_count = 0;
    int          beat_no = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          idle_en = 1'b1;
    logic        plant_pump = 1'b0;
    logic        plant_valve = 1'b0;
    logic [31:0] clk_ms = '0;
    logic [31:0] flow_vol = '0;

    function automatic void close_transfer(input logic [31:0] now);
        if (xfer_ph == XFER_INACTIVE) return;
        pump_cmd = PUMP_OFF;
        valve_cmd = VALVE_STIR;
        xfer_ph = XFER_INACTIVE;
        if (stir_ph == STIR_SUSPENDED) begin
            stir_ph = STIR_ON;
            phase_t0 = now;
            pump_cmd = PUMP_ON;
        end
    endfunction

    function automatic pts_result_t predict_step(input pts_item_t it);
        logic        pump_run, valve_tr, moving;
        logic [31:0] elapsed, span;
        longint      diff;
        pts_result_t r;
        pump_cmd = PUMP_NONE;
        valve_cmd = VALVE_NONE;
        case (it.func)
            FUNC_UPDATE: begin
                if (xfer_ph == XFER_DONE) close_transfer(it.time_ms);
                pump_run = (pump_cmd == PUMP_NONE) ? it.pump_feedback : (pump_cmd == PUMP_ON);
                valve_tr = (valve_cmd == VALVE_NONE) ? it.valve_feedback
                                                     : (valve_cmd == VALVE_TRANSFER);
                moving = pump_run && valve_tr;
                if (moving && xfer_ph == XFER_INACTIVE && !manual_seen) begin
                    manual_seen = 1'b1;
                    base_vol = it.session_volume;
                    moved_vol = '0;
                end
                if (manual_seen && !moving) manual_seen = 1'b0;
                if (moving) begin
                    diff = longint'(it.session_volume) - longint'(base_vol);
                    if (diff > 64'sd2147483647) diff = 64'sd2147483647;
                    if (diff < -64'sd2147483648) diff = -64'sd2147483648;
                    moved_vol = 32'(diff);
                end
                if (xfer_ph == XFER_RUNNING &&
                    longint'(moved_vol) >= longint'(held_target) * 256) begin
                    pump_cmd = PUMP_OFF;
                    valve_cmd = VALVE_STIR;
                    xfer_ph = XFER_DONE;
                end
                elapsed = it.time_ms - phase_t0;
                if (stir_ph == STIR_ON) begin
                    if (elapsed >= 32'(held_on_ms)) begin
                        pump_cmd = PUMP_OFF;
                        stir_ph = STIR_PAUSE;
                        phase_t0 = it.time_ms;
                    end
                end else if (stir_ph == STIR_PAUSE) begin
                    if (elapsed >= 32'(held_off_ms)) begin
                        valve_cmd = VALVE_STIR;
                        pump_cmd = PUMP_ON;
                        stir_ph = STIR_ON;
                        phase_t0 = it.time_ms;
                    end
                end
            end
            FUNC_XFER_START: begin
                if (xfer_ph != XFER_RUNNING) begin
                    held_target = reg_target;
                    base_vol = it.session_volume;
                    xfer_ph = XFER_RUNNING;
                    moved_vol = '0;
                    valve_cmd = VALVE_TRANSFER;
                    pump_cmd = PUMP_ON;
                    if (stir_ph == STIR_ON || stir_ph == STIR_PAUSE) stir_ph = STIR_SUSPENDED;
                end
            end
            FUNC_XFER_STOP: close_transfer(it.time_ms);
            FUNC_STIR_START: begin
                if (stir_ph == STIR_INACTIVE) begin
                    held_on_ms = 26'(32'(reg_on_s) * 32'(MS_PER_S));
                    held_off_ms = 26'(32'(reg_off_s) * 32'(MS_PER_S));
                    phase_t0 = it.time_ms;
                    if (xfer_ph == XFER_RUNNING) begin
                        stir_ph = STIR_SUSPENDED;
                    end else begin
                        stir_ph = STIR_ON;
                        valve_cmd = VALVE_STIR;
                        pump_cmd = PUMP_ON;
                    end
                end
            end
            FUNC_STIR_STOP: begin
                if (stir_ph != STIR_INACTIVE) begin
                    if (xfer_ph != XFER_RUNNING) pump_cmd = PUMP_OFF;
                    stir_ph = STIR_INACTIVE;
                end
            end
            FUNC_STOP_ALL: begin
                if (xfer_ph != XFER_INACTIVE || stir_ph != STIR_INACTIVE) begin
                    if (xfer_ph == XFER_RUNNING) begin
                        pump_cmd = PUMP_OFF;
                        valve_cmd = VALVE_STIR;
                    end else if (stir_ph == STIR_ON) begin
                        pump_cmd = PUMP_OFF;
                    end
                    xfer_ph = XFER_INACTIVE;
                    stir_ph = STIR_INACTIVE;
                end
            end
            default: ;
        endcase
        r.stir_remaining_ms = '0;
        if (stir_ph == STIR_ON || stir_ph == STIR_PAUSE) begin
            span = (stir_ph == STIR_ON) ? 32'(held_on_ms) : 32'(held_off_ms);
            elapsed = it.time_ms - phase_t0;
            r.stir_remaining_ms = (elapsed >= span) ? 26'd0 : 26'(span - elapsed);
        end
        r.pump_drive = pump_cmd;
        r.valve_drive = valve_cmd;
        r.transfer_status = xfer_ph;
        r.stir_status = stir_ph;
        r.manual_transfer = manual_seen;
        r.moved_volume = moved_vol;
        return r;
    endfunction

    // sender: bursts with random gaps; valid stays high across a burst
    task automatic send_beat(input logic [2:0] f, input logic [31:0] t, v,
                             input logic pf, vf);
        pts_item_t it;
        int        gap;
        it.func = f;
        it.time_ms = t;
        it.session_volume = v;
        it.pump_feedback = pf;
        it.valve_feedback = vf;
        if (burst_left == 0) begin
            gap = idle_en ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {6'b0, vf, pf, v, t};
        do @(posedge aclk); while (!s_tready);
        results_due.push_back(predict_step(it));
        if (pump_cmd != PUMP_NONE) plant_pump = (pump_cmd == PUMP_ON);
        if (valve_cmd != VALVE_NONE) plant_valve = (valve_cmd == VALVE_TRANSFER);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TARGET_LITRES: reg_target = val;
            REG_STIR_ON_SEC:   reg_on_s = val;
            REG_STIR_OFF_SEC:  reg_off_s = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic write_config(input logic [15:0] tgt, on_s, off_s);
        drain_results();
        write_reg(REG_TARGET_LITRES, tgt);
        write_reg(REG_STIR_ON_SEC, on_s);
        write_reg(REG_STIR_OFF_SEC, off_s);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_codes();
        write_config(16'd0, 16'd0, 16'd0);
        send_beat(FUNC_UPDATE, 32'd0, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_NOP_A, 32'd5, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_NOP_B, 32'd6, 32'd0, 1'b1, 1'b1);
        send_beat(FUNC_STOP_ALL, 32'd7, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_XFER_STOP, 32'd8, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_STIR_STOP, 32'd9, 32'd0, 1'b0, 1'b0);
    endtask

    task automatic test_transfer_and_stir();
        write_config(16'd2, 16'd1, 16'd1);
        send_beat(FUNC_STIR_START, 32'd100, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_STIR_START, 32'd200, 32'd0, 1'b1, 1'b0);
        send_beat(FUNC_UPDATE, 32'd1100, 32'd0, 1'b1, 1'b0);
        send_beat(FUNC_XFER_START, 32'd1150, 32'h100, 1'b0, 1'b0);
        send_beat(FUNC_XFER_START, 32'd1160, 32'h200, 1'b1, 1'b1);
        send_beat(FUNC_UPDATE, 32'd1200, 32'h300, 1'b1, 1'b1);
        send_beat(FUNC_XFER_START, 32'd1250, 32'h300, 1'b0, 1'b0);
        send_beat(FUNC_UPDATE, 32'd1260, 32'h500, 1'b1, 1'b1);
        send_beat(FUNC_UPDATE, 32'd1300, 32'h500, 1'b1, 1'b1);
        send_beat(FUNC_XFER_START, 32'd1400, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_beat(FUNC_UPDATE, 32'd1500, 32'h0, 1'b1, 1'b1);
        send_beat(FUNC_XFER_STOP, 32'd1600, 32'h0, 1'b1, 1'b1);
        send_beat(FUNC_STOP_ALL, 32'd1700, 32'h0, 1'b1, 1'b0);
    endtask

    task automatic test_manual_flow();
        send_beat(FUNC_UPDATE, 32'd2000, 32'h0, 1'b1, 1'b1);
        send_beat(FUNC_UPDATE, 32'd2100, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(FUNC_UPDATE, 32'd2200, 32'hFFFF_FFFF, 1'b1, 1'b0);
    endtask

    task automatic test_time_wrap();
        write_config(16'hFFFF, 16'hFFFF, 16'd0);
        send_beat(FUNC_STIR_START, 32'hFFFF_FF00, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_UPDATE, 32'h0000_0100, 32'd0, 1'b1, 1'b0);
        send_beat(FUNC_UPDATE, 32'hFFFF_FE00, 32'd0, 1'b1, 1'b0);
        send_beat(FUNC_UPDATE, 32'hFFFF_FE00, 32'd0, 1'b0, 1'b0);
        send_beat(FUNC_XFER_START, 32'hFFFF_FF00, 32'h1234_5678, 1'b1, 1'b0);
        send_beat(FUNC_STIR_STOP, 32'hFFFF_FF10, 32'd0, 1'b1, 1'b1);
        send_beat(FUNC_STIR_START, 32'hFFFF_FF20, 32'd0, 1'b1, 1'b1);
        send_beat(FUNC_STOP_ALL, 32'hFFFF_FF30, 32'd0, 1'b1, 1'b1);
    endtask

    task automatic random_beats(input int n, input bit pause_mid);
        logic [2:0] f;
        logic       pf, vf;
        int         r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      f = FUNC_UPDATE;
            else if (r < 63) f = FUNC_XFER_START;
            else if (r < 69) f = FUNC_XFER_STOP;
            else if (r < 77) f = FUNC_STIR_START;
            else if (r < 83) f = FUNC_STIR_STOP;
            else if (r < 88) f = FUNC_STOP_ALL;
            else if (r < 90) f = FUNC_NOP_A;
            else if (r < 92) f = FUNC_NOP_B;
            else             f = FUNC_UPDATE;
            r = $urandom_range(0, 99);
            if (r < 85)      clk_ms += $urandom_range(0, 1500);
            else if (r < 92) clk_ms += $urandom_range(0, 70000000);
            else if (r < 96) clk_ms = $urandom;
            else             clk_ms -= $urandom_range(1, 5000);
            r = $urandom_range(0, 99);
            if (r < 90) begin
                if (plant_pump && plant_valve) flow_vol += $urandom_range(0, 700);
            end else if (r < 95) begin
                flow_vol = $urandom;
            end else begin
                flow_vol -= $urandom_range(0, 2000);
            end
            pf = ($urandom_range(0, 99) < 85) ? plant_pump : 1'($urandom);
            vf = ($urandom_range(0, 99) < 85) ? plant_valve : 1'($urandom);
            send_beat(f, clk_ms, flow_vol, pf, vf);
            if (pause_mid && i == n / 2) drain_results();
        end
    endtask

    task automatic test_random_stream();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_config(16'd0, 16'd0, 16'd0);
                1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_config(16'($urandom), 16'($urandom), 16'($urandom));
                default: write_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 4)),
                                      16'($urandom_range(0, 4)));
            endcase
            idle_en = (ph % 3) != 1;
            random_beats(250, ph == 4);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_codes();
        test_transfer_and_stir();
        test_manual_flow();
        test_time_wrap();
        test_random_stream();
        drain_results();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver stall pattern: free-running, mostly-ready and mostly-stalled stretches
    int stall_left = 0;
    int stall_mode = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        pts_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pump_drive = pts_pump_t'(m_tdata[1:0]);
            got.valve_drive = pts_valve_t'(m_tdata[3:2]);
            got.transfer_status = pts_xfer_t'(m_tdata[5:4]);
            got.stir_status = pts_stir_t'(m_tdata[7:6]);
            got.manual_transfer = m_tdata[8];
            got.moved_volume = m_tdata[40:9];
            got.stir_remaining_ms = m_tdata[66:41];
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("beat %0d: unexpected result %h", beat_no, m_tdata);
            end else begin
                want = results_due.pop_front();
                if (got.pump_drive !== want.pump_drive ||
                    got.valve_drive !== want.valve_drive ||
                    got.transfer_status !== want.transfer_status ||
                    got.stir_status !== want.stir_status ||
                    got.manual_transfer !== want.manual_transfer ||
                    got.moved_volume !== want.moved_volume ||
                    got.stir_remaining_ms !== want.stir_remaining_ms) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("beat %0d mismatch (exp/got): pump %0d/%0d valve %0d/%0d",
                                 beat_no, want.pump_drive, got.pump_drive,
                                 want.valve_drive, got.valve_drive);
                        $display("  xfer %0d/%0d stir %0d/%0d manual %0b/%0b",
                                 want.transfer_status, got.transfer_status,
                                 want.stir_status, got.stir_status,
                                 want.manual_transfer, got.manual_transfer);
                        $display("  moved %0d/%0d remaining %0d/%0d",
                                 want.moved_volume, got.moved_volume,
                                 want.stir_remaining_ms, got.stir_remaining_ms);
                    end
                end
            end
            beat_no++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/pts_pkg.sv
rtl/pts_cfg_regs.sv
rtl/pts_core.sv
rtl/pump_transfer_and_stir_sequencer.sv
test/tb.sv
